### rtl/core/sfb_pkg.sv
// Package for the seven-segment frame builder: request types, command bytes and the digit table.
`timescale 1ns / 1ps
`default_nettype none
package sfb_pkg;

    // Number of digits shown, used as the default of the top-level parameter.
    localparam int DIGIT_COUNT_DEF = 4;

    // Field widths.
    localparam int VALUE_W  = 14;
    localparam int BRIGHT_W = 4;
    localparam int BYTE_W   = 8;
    localparam int DIGIT_W  = 4;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_BRIGHTNESS = 3'd0;

    // Command bytes and the separator segment.
    localparam logic [BYTE_W-1:0] CMD_DATA   = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_ADDR   = 8'hC0;
    localparam logic [BYTE_W-1:0] CMD_BRIGHT = 8'h87;
    localparam logic [BYTE_W-1:0] SEP_BIT    = 8'h80;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 4'd8;

    // Digit position that carries the separator segment.
    localparam int SEP_DIGIT = 2;

    // Division by ten: quotient = (value * DIV10_MUL) >> DIV10_SHIFT, exact below 2**14.
    localparam int DIV10_MUL_W = 13;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 13'd6554;
    localparam int DIV10_SHIFT = 16;

    // Operating mode of a request.
    localparam logic MODE_DISPLAY = 1'b0;
    localparam logic MODE_BRIGHT  = 1'b1;

    // Input request.
    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] value;
        logic               separator;
    } t_in_req;

    // Output frame byte.
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              start_before;
        logic              stop_after;
        logic              last;
    } t_out_rsp;

    // Work carried down the digit pipeline.
    typedef struct packed {
        logic               mode;
        logic               separator;
        logic [VALUE_W-1:0] rest;
    } t_work;

    // Seven-segment code of one decimal digit, bit 0 is segment a.
    function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [BYTE_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

### rtl/core/sfb_digit_stage.sv
// One pipeline stage that peels off a decimal digit and stores its segment code.
`timescale 1ns / 1ps
`default_nettype none
module sfb_digit_stage #(
    parameter int DIGIT_COUNT = sfb_pkg::DIGIT_COUNT_DEF,
    parameter int STAGE       = 0
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire sfb_pkg::t_work                  i_work,
    input  wire [DIGIT_COUNT-1:0][sfb_pkg::BYTE_W-1:0] i_codes,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output sfb_pkg::t_work                       o_work,
    output logic [DIGIT_COUNT-1:0][sfb_pkg::BYTE_W-1:0] o_codes
);

    localparam int PROD_W = sfb_pkg::VALUE_W + sfb_pkg::DIV10_MUL_W;
    localparam int QUOT_W = PROD_W - sfb_pkg::DIV10_SHIFT;

    logic                       r_valid;
    sfb_pkg::t_work             r_work;
    logic [DIGIT_COUNT-1:0][sfb_pkg::BYTE_W-1:0] r_codes;

    logic [PROD_W-1:0]          product;
    logic [QUOT_W-1:0]          quotient;
    logic [sfb_pkg::VALUE_W-1:0] quot_wide;
    logic [sfb_pkg::VALUE_W-1:0] remainder;
    logic [sfb_pkg::BYTE_W-1:0]  code;
    sfb_pkg::t_work              n_work;
    logic [DIGIT_COUNT-1:0][sfb_pkg::BYTE_W-1:0] n_codes;

    // Divide the remaining value by ten through a reciprocal multiply.
    always_comb begin
        product   = PROD_W'(i_work.rest) * PROD_W'(sfb_pkg::DIV10_MUL);
        quotient  = product[PROD_W-1:sfb_pkg::DIV10_SHIFT];
        quot_wide = sfb_pkg::VALUE_W'(quotient);
        remainder = i_work.rest - ((quot_wide << 3) + (quot_wide << 1));
    end

    // Map the digit and light the separator on the hundreds place when asked.
    always_comb begin
        code = sfb_pkg::seg_code(remainder[sfb_pkg::DIGIT_W-1:0]);
        if (STAGE == sfb_pkg::SEP_DIGIT && i_work.separator) begin
            code = code | sfb_pkg::SEP_BIT;
        end
        n_codes        = i_codes;
        n_codes[STAGE] = code;
        n_work         = i_work;
        n_work.rest    = quot_wide;
    end

    // The stage holds while its content is valid and the next stage stalls.
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_work  <= n_work;
            r_codes <= n_codes;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;
    assign o_codes = r_codes;

`ifndef SYNTHESIS
    // A stalled stage keeps its request.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_work) && $stable(r_codes))
        else $error("digit stage lost a stalled request");

    // Stall towards the upstream side is raised only with a request in the stage.
    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_valid)
        else $error("digit stage stalls while empty");

    // The stored digit code always carries a valid segment pattern.
    a_code_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_codes[STAGE][6:0] != 7'h00))
        else $error("digit stage stored an empty segment code");
`endif

endmodule
`default_nettype wire

### rtl/core/sfb_serializer.sv
// Frame sequencer that turns one finished request into its run of framed bytes.
`timescale 1ns / 1ps
`default_nettype none
module sfb_serializer #(
    parameter int DIGIT_COUNT = sfb_pkg::DIGIT_COUNT_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire [sfb_pkg::BRIGHT_W-1:0]          i_brightness,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire sfb_pkg::t_work                  i_work,
    input  wire [DIGIT_COUNT-1:0][sfb_pkg::BYTE_W-1:0] i_codes,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output sfb_pkg::t_out_rsp                    o_rsp
);

    localparam int BYTE_COUNT = DIGIT_COUNT + 2;
    localparam int IW         = $clog2(BYTE_COUNT);
    localparam logic [IW-1:0] LAST_IDX = IW'(BYTE_COUNT - 1);

    logic                       r_busy;
    logic                       r_mode;
    logic [IW-1:0]              r_idx;
    logic [DIGIT_COUNT-1:0][sfb_pkg::BYTE_W-1:0] r_codes;
    logic                       r_out_valid;
    sfb_pkg::t_out_rsp          r_out;

    logic                       out_free;
    logic                       emit;
    logic                       load;
    logic [sfb_pkg::BRIGHT_W-1:0] bright_sat;
    sfb_pkg::t_out_rsp          n_out;

    // Saturate the brightness level.
    always_comb begin
        if (i_brightness > sfb_pkg::BRIGHT_MAX) begin
            bright_sat = sfb_pkg::BRIGHT_MAX;
        end else begin
            bright_sat = i_brightness;
        end
    end

    // Select the byte for the current position of the held request.
    always_comb begin
        n_out = '0;
        if (r_mode == sfb_pkg::MODE_BRIGHT) begin
            n_out.frame_byte   = sfb_pkg::CMD_BRIGHT + sfb_pkg::BYTE_W'(bright_sat);
            n_out.start_before = 1'b1;
            n_out.stop_after   = 1'b1;
            n_out.last         = 1'b1;
        end else if (r_idx == IW'(0)) begin
            n_out.frame_byte   = sfb_pkg::CMD_DATA;
            n_out.start_before = 1'b1;
            n_out.stop_after   = 1'b1;
        end else if (r_idx == IW'(1)) begin
            n_out.frame_byte   = sfb_pkg::CMD_ADDR;
            n_out.start_before = 1'b1;
        end else begin
            for (int j = 0; j < DIGIT_COUNT; j++) begin
                if (r_idx == IW'(DIGIT_COUNT + 1 - j)) begin
                    n_out.frame_byte = r_codes[j];
                end
            end
            n_out.stop_after = (r_idx == LAST_IDX);
            n_out.last       = (r_idx == LAST_IDX);
        end
    end

    // Handshake between the held request and the output register.
    assign out_free = !r_out_valid || !i_stall;
    assign emit     = r_busy && out_free;
    assign load     = !r_busy || (emit && n_out.last);
    assign o_stall  = !load;

    // Request holder and byte position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= i_valid;
            r_idx  <= '0;
        end else if (emit) begin
            r_idx  <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_mode  <= i_work.mode;
            r_codes <= i_codes;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

`ifndef SYNTHESIS
    // The byte position never runs past the final byte of a frame.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= LAST_IDX)
        else $error("serializer position beyond the frame");

    // An idle sequencer always waits at the first byte.
    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_idx == '0)
        else $error("serializer idle away from the first byte");

    // Every request ends with a stop condition.
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last |-> r_out.stop_after)
        else $error("final byte without a stop condition");

    // The first byte of a frame always opens with a start condition.
    a_start_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && !n_out.start_before |-> r_idx != '0)
        else $error("first byte of a frame without a start condition");
`endif

endmodule
`default_nettype wire

### rtl/core/seven_segment_frame_builder.sv
// Top level of the seven-segment frame builder: register port, digit pipeline and sequencer.
//
//   channel   direction  signals                                     content
//   request   in         i_in_valid, o_in_stall, i_in_req            mode, value, separator
//   frame     out        o_out_valid, i_out_stall, o_out_rsp         one framed byte
//   register  in/out     psel, penable, pwrite, paddr, pwdata,
//                        prdata, pready                              brightness at 0x0
//
// A display request gives DIGIT_COUNT + 2 bytes and a brightness request one byte, sent by
// the frame sequencer one byte per cycle while the frame side does not stall. A request
// reaches the first byte through the digit stages, the sequencer and the output register.
// Digit stages take a request every cycle unless stalled; the sequencer takes one per frame.
// Synchronous active-low reset empties the pipeline and sets brightness to 8.
// A stall on the frame side backs up stage by stage; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_frame_builder #(
    parameter int DIGIT_COUNT = sfb_pkg::DIGIT_COUNT_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire sfb_pkg::t_in_req              i_in_req,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output sfb_pkg::t_out_rsp                  o_out_rsp,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [sfb_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [sfb_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sfb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic [sfb_pkg::BRIGHT_W-1:0] r_brightness;

    logic           w_valid [DIGIT_COUNT+1];
    logic           w_stall [DIGIT_COUNT+1];
    sfb_pkg::t_work w_work  [DIGIT_COUNT+1];
    logic [DIGIT_COUNT-1:0][sfb_pkg::BYTE_W-1:0] w_codes [DIGIT_COUNT+1];

    // Register port: always ready, brightness written on the access cycle.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= sfb_pkg::BRIGHT_MAX;
        end else if (psel && penable && pwrite && paddr == sfb_pkg::ADDR_BRIGHTNESS) begin
            r_brightness <= pwdata[sfb_pkg::BRIGHT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == sfb_pkg::ADDR_BRIGHTNESS) begin
            prdata = sfb_pkg::APB_DATA_W'(r_brightness);
        end
    end

    // Pipeline entry.
    always_comb begin
        w_valid[0]          = i_in_valid;
        w_work[0].mode      = i_in_req.mode;
        w_work[0].separator = i_in_req.separator;
        w_work[0].rest      = i_in_req.value;
        w_codes[0]          = '0;
    end
    assign o_in_stall = w_stall[0];

    // One stage per decimal digit, ones digit first.
    for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_digit
        sfb_digit_stage #(
            .DIGIT_COUNT (DIGIT_COUNT),
            .STAGE       (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_stall (w_stall[g]),
            .i_work  (w_work[g]),
            .i_codes (w_codes[g]),
            .o_valid (w_valid[g+1]),
            .i_stall (w_stall[g+1]),
            .o_work  (w_work[g+1]),
            .o_codes (w_codes[g+1])
        );
    end

    // Frame sequencer and output register.
    sfb_serializer #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_brightness (r_brightness),
        .i_valid      (w_valid[DIGIT_COUNT]),
        .o_stall      (w_stall[DIGIT_COUNT]),
        .i_work       (w_work[DIGIT_COUNT]),
        .i_codes      (w_codes[DIGIT_COUNT]),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_rsp        (o_out_rsp)
    );

endmodule
`default_nettype wire
